[rtl/iis_pkg.sv]
`default_nettype none
package iis_pkg;

  typedef logic signed [63:0] word_t;

  localparam word_t WORD_MIN = {1'b1, 63'd0};
  localparam word_t WORD_MAX = {1'b0, {63{1'b1}}};

  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0,
    FUNC_DELETE = 3'd1,
    FUNC_QUERY  = 3'd2,
    FUNC_ADD    = 3'd3,
    FUNC_SUB    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  // Source of the interval fed into the merge stage.
  typedef enum logic [1:0] {
    SEL_CAND,
    SEL_OP,
    SEL_LO_VM1,
    SEL_VP1_HI
  } sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_RD,
    S_LOAD,
    S_EVAL,
    S_FEED,
    S_FLUSH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load_op;
    logic prep;
    logic rd;
    logic load_cand;
    logic feed;
    sel_e sel;
    logic flush;
    logic set_present;
    logic capture_hit;
    logic set_drop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       bad;
    logic       idx_end;
    logic       full;
    logic       hit;
    logic       eq_lo;
    logic       eq_hi;
    logic       lt;
    logic       out_busy;
  } sts_t;

  // Saturating signed add; bit 64 of the result flags a clamp.
  function automatic logic [64:0] sat_add(word_t a, word_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return {1'b1, (s[64] ? WORD_MIN : WORD_MAX)};
    end
    return {1'b0, s[63:0]};
  endfunction

endpackage
`default_nettype wire

[rtl/iis_ram.sv]
`default_nettype none
module iis_ram #(
  parameter int Width = 128,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/iis_ctrl.sv]
`default_nettype none
module iis_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire iis_pkg::sts_t sts_i,
  output iis_pkg::cmd_t      cmd_o
);

  iis_pkg::state_e state_q, state_d;
  iis_pkg::sel_e   sel_q, sel_d, sel2_q, sel2_d;
  logic            has2_q, has2_d;
  logic            inserted_q, inserted_d;
  logic            is_ins, uses_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= iis_pkg::S_IDLE;
      sel_q      <= iis_pkg::SEL_CAND;
      sel2_q     <= iis_pkg::SEL_CAND;
      has2_q     <= 1'b0;
      inserted_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      sel_q      <= sel_d;
      sel2_q     <= sel2_d;
      has2_q     <= has2_d;
      inserted_q <= inserted_d;
    end
  end

  always_comb begin
    is_ins  = (sts_i.func == iis_pkg::FUNC_INSERT);
    uses_op = is_ins || (sts_i.func == iis_pkg::FUNC_ADD) ||
              (sts_i.func == iis_pkg::FUNC_SUB);
    state_d    = state_q;
    sel_d      = sel_q;
    sel2_d     = sel2_q;
    has2_d     = has2_q;
    inserted_d = inserted_q;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      iis_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_op = 1'b1;
          inserted_d    = 1'b0;
          has2_d        = 1'b0;
          state_d       = iis_pkg::S_PREP;
        end
      end
      iis_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        if (uses_op && sts_i.bad) begin
          state_d = iis_pkg::S_DONE;
        end else if (uses_op || (sts_i.func == iis_pkg::FUNC_DELETE) ||
                     (sts_i.func == iis_pkg::FUNC_QUERY)) begin
          state_d = iis_pkg::S_RD;
        end else begin
          state_d = iis_pkg::S_DONE;
        end
      end
      iis_pkg::S_RD: begin
        if (!sts_i.idx_end) begin
          cmd_o.rd = 1'b1;
          state_d  = iis_pkg::S_LOAD;
        end else if (is_ins && !inserted_q) begin
          // The new interval sorts after every stored one.
          sel_d      = iis_pkg::SEL_OP;
          has2_d     = 1'b0;
          inserted_d = 1'b1;
          state_d    = iis_pkg::S_FEED;
        end else begin
          state_d = iis_pkg::S_FLUSH;
        end
      end
      iis_pkg::S_LOAD: begin
        cmd_o.load_cand = 1'b1;
        state_d         = iis_pkg::S_EVAL;
      end
      iis_pkg::S_EVAL: begin
        sel_d   = iis_pkg::SEL_CAND;
        has2_d  = 1'b0;
        state_d = iis_pkg::S_FEED;
        unique case (sts_i.func)
          iis_pkg::FUNC_INSERT: begin
            if (!inserted_q && !sts_i.lt) begin
              sel_d      = iis_pkg::SEL_OP;
              sel2_d     = iis_pkg::SEL_CAND;
              has2_d     = 1'b1;
              inserted_d = 1'b1;
            end
          end
          iis_pkg::FUNC_DELETE: begin
            if (sts_i.hit) begin
              cmd_o.set_present = 1'b1;
              priority if (sts_i.eq_lo && sts_i.eq_hi) begin
                state_d = iis_pkg::S_RD;
              end else if (sts_i.eq_lo) begin
                sel_d = iis_pkg::SEL_VP1_HI;
              end else if (sts_i.eq_hi) begin
                sel_d = iis_pkg::SEL_LO_VM1;
              end else if (sts_i.full) begin
                cmd_o.set_drop = 1'b1;
              end else begin
                sel_d  = iis_pkg::SEL_LO_VM1;
                sel2_d = iis_pkg::SEL_VP1_HI;
                has2_d = 1'b1;
              end
            end
          end
          iis_pkg::FUNC_QUERY: begin
            if (sts_i.hit) begin
              cmd_o.set_present = 1'b1;
              cmd_o.capture_hit = 1'b1;
            end
            state_d = iis_pkg::S_RD;
          end
          default: ;
        endcase
      end
      iis_pkg::S_FEED: begin
        cmd_o.feed = 1'b1;
        if (has2_q) begin
          sel_d  = sel2_q;
          has2_d = 1'b0;
        end else begin
          state_d = iis_pkg::S_RD;
        end
      end
      iis_pkg::S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = iis_pkg::S_DONE;
      end
      iis_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = iis_pkg::S_IDLE;
        end
      end
      default: state_d = iis_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/iis_dp.sv]
`default_nettype none
module iis_dp #(
  parameter int MaxIntervals = 16,
  localparam int IdxW = $clog2(MaxIntervals),
  localparam int CntW = $clog2(MaxIntervals + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire iis_pkg::cmd_t cmd_i,
  output iis_pkg::sts_t      sts_o,
  input  wire logic [2:0]    func_i,
  input  wire logic signed [63:0] range_lo_i,
  input  wire logic signed [63:0] range_hi_i,
  input  wire logic signed [63:0] point_value_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         status_o,
  output logic               present_o,
  output logic               saturated_o,
  output logic [CntW-1:0]    interval_count_o,
  output logic signed [63:0] hit_lo_o,
  output logic signed [63:0] hit_hi_o
);

  localparam int RamDepth = 2 ** (IdxW + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxIntervals);

  logic [2:0]     func_q;
  iis_pkg::word_t op_lo_q, op_hi_q, v_q, add_a_q, add_b_q, vp1_q, vm1_q;
  iis_pkg::word_t cand_lo_q, cand_hi_q, plo_q, phi_q, hit_lo_q, hit_hi_q;
  logic           bad_q, clamp_q, present_q, drop_q, ovf_q, pvalid_q;
  logic           hit_q, eq_lo_q, eq_hi_q, lt_q;
  logic [CntW-1:0] idx_q, m_q, count_q;
  logic           bank_q;

  logic           out_valid_q;
  logic [1:0]     status_oq;
  logic           present_oq, sat_oq;
  logic [CntW-1:0] cnt_oq;
  iis_pkg::word_t hit_lo_oq, hit_hi_oq;

  logic [127:0]   rdata;
  iis_pkg::word_t r_lo, r_hi, f_lo, f_hi, phi_p1;
  logic [64:0]    s_lo, s_hi, neg_a, neg_b;
  logic           joins, emit, we, is_shift, writes_tbl, commit;
  logic [IdxW:0]  waddr, raddr;

  iis_ram #(.Width(128), .Depth(RamDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i({phi_q, plo_q}),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  function automatic logic [64:0] sat_neg(iis_pkg::word_t a);
    if (a == iis_pkg::WORD_MIN) begin
      return {1'b1, iis_pkg::WORD_MAX};
    end
    return {1'b0, -a};
  endfunction

  always_comb begin
    r_lo  = rdata[63:0];
    r_hi  = rdata[127:64];
    s_lo  = iis_pkg::sat_add(r_lo, add_a_q);
    s_hi  = iis_pkg::sat_add(r_hi, add_b_q);
    neg_a = sat_neg(op_hi_q);
    neg_b = sat_neg(op_lo_q);
    is_shift = (func_q == iis_pkg::FUNC_ADD) || (func_q == iis_pkg::FUNC_SUB);
    writes_tbl = is_shift || (func_q == iis_pkg::FUNC_INSERT) ||
                 (func_q == iis_pkg::FUNC_DELETE);
    commit = writes_tbl && !bad_q && !drop_q && !ovf_q;
    unique case (cmd_i.sel)
      iis_pkg::SEL_CAND:   begin f_lo = cand_lo_q; f_hi = cand_hi_q; end
      iis_pkg::SEL_OP:     begin f_lo = op_lo_q;   f_hi = op_hi_q;   end
      iis_pkg::SEL_LO_VM1: begin f_lo = cand_lo_q; f_hi = vm1_q;     end
      iis_pkg::SEL_VP1_HI: begin f_lo = vp1_q;     f_hi = cand_hi_q; end
      default:             begin f_lo = cand_lo_q; f_hi = cand_hi_q; end
    endcase
    // Touching intervals join too; the top value always joins, so the
    // increment cannot wrap in a case that matters.
    phi_p1 = phi_q + 64'sd1;
    joins  = (phi_q == iis_pkg::WORD_MAX) || (phi_p1 >= f_lo);
    emit   = pvalid_q && ((cmd_i.feed && !joins) || cmd_i.flush);
    we     = emit && (m_q < MaxCnt);
    waddr  = {~bank_q, m_q[IdxW-1:0]};
    raddr  = {bank_q, idx_q[IdxW-1:0]};

    sts_o.func     = func_q;
    sts_o.bad      = (op_lo_q > op_hi_q);
    sts_o.idx_end  = (idx_q == count_q);
    sts_o.full     = (count_q >= MaxCnt);
    sts_o.hit      = hit_q;
    sts_o.eq_lo    = eq_lo_q;
    sts_o.eq_hi    = eq_hi_q;
    sts_o.lt       = lt_q;
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      m_q         <= '0;
      pvalid_q    <= 1'b0;
      drop_q      <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_op) begin
        idx_q    <= '0;
        m_q      <= '0;
        pvalid_q <= 1'b0;
        drop_q   <= 1'b0;
        ovf_q    <= 1'b0;
      end
      if (cmd_i.load_cand) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_drop) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.feed) begin
        pvalid_q <= 1'b1;
      end
      if (emit) begin
        if (m_q < MaxCnt) begin
          m_q <= m_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (commit) begin
          count_q <= m_q;
          bank_q  <= ~bank_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      func_q    <= func_i;
      op_lo_q   <= range_lo_i;
      op_hi_q   <= range_hi_i;
      v_q       <= point_value_i;
      clamp_q   <= 1'b0;
      present_q <= 1'b0;
      hit_lo_q  <= '0;
      hit_hi_q  <= '0;
    end
    if (cmd_i.prep) begin
      // Only requests that take an interval operand can have a bad one.
      bad_q <= (op_lo_q > op_hi_q) && (is_shift || (func_q == iis_pkg::FUNC_INSERT));
      vp1_q <= v_q + 64'sd1;
      vm1_q <= v_q - 64'sd1;
      if (func_q == iis_pkg::FUNC_SUB) begin
        add_a_q <= neg_a[63:0];
        add_b_q <= neg_b[63:0];
        if (!(op_lo_q > op_hi_q)) begin
          clamp_q <= neg_a[64] | neg_b[64];
        end
      end else begin
        add_a_q <= op_lo_q;
        add_b_q <= op_hi_q;
      end
    end
    if (cmd_i.load_cand) begin
      hit_q   <= (r_lo <= v_q) && (v_q <= r_hi);
      eq_lo_q <= (r_lo == v_q);
      eq_hi_q <= (r_hi == v_q);
      lt_q    <= (r_lo < op_lo_q);
      if (is_shift) begin
        cand_lo_q <= s_lo[63:0];
        cand_hi_q <= s_hi[63:0];
        if (s_lo[64] || s_hi[64]) begin
          clamp_q <= 1'b1;
        end
      end else begin
        cand_lo_q <= r_lo;
        cand_hi_q <= r_hi;
      end
    end
    if (cmd_i.set_present) begin
      present_q <= 1'b1;
    end
    if (cmd_i.capture_hit) begin
      hit_lo_q <= cand_lo_q;
      hit_hi_q <= cand_hi_q;
    end
    if (cmd_i.feed) begin
      if (pvalid_q && joins) begin
        if (f_hi > phi_q) begin
          phi_q <= f_hi;
        end
      end else begin
        plo_q <= f_lo;
        phi_q <= f_hi;
      end
    end
    if (cmd_i.finish) begin
      priority if (bad_q && (writes_tbl && func_q != iis_pkg::FUNC_DELETE)) begin
        status_oq <= iis_pkg::STATUS_BAD;
      end else if (writes_tbl && (drop_q || ovf_q)) begin
        status_oq <= iis_pkg::STATUS_FULL;
      end else begin
        status_oq <= iis_pkg::STATUS_OK;
      end
      present_oq <= present_q;
      sat_oq     <= is_shift && clamp_q;
      cnt_oq     <= commit ? m_q : count_q;
      hit_lo_oq  <= hit_lo_q;
      hit_hi_oq  <= hit_hi_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_oq;
  assign present_o        = present_oq;
  assign saturated_o      = sat_oq;
  assign interval_count_o = cnt_oq;
  assign hit_lo_o         = hit_lo_oq;
  assign hit_hi_o         = hit_hi_oq;

endmodule
`default_nettype wire

[rtl/integer_interval_set.sv]
// Sorted set of disjoint signed 64-bit intervals with automatic coalescing of
// touching neighbors. Each request inserts an interval, deletes or queries one
// value, or shifts every stored interval by a saturating add or subtract.
// Every request with a known function and a good operand walks the table once
// out of one bank of a two-bank RAM; a write-type request streams it through
// a merge stage into the other bank, and a successful one swaps banks. The
// walk goes through the single RAM read port: setup, then per entry a read,
// load, decide and merge step, then an end-of-table check, flush and result.
// An insert adds a merge step for the new interval, and a split adds one for
// its second piece; a query and a removed singleton take no merge step for
// their entry. A bad operand or an unknown function finishes without walking
// the table. A new request is taken in the cycle after the previous result
// has been registered, and a result that is not taken holds back the next
// one. The table is empty after reset and needs no clearing.
`default_nettype none
module integer_interval_set #(
  parameter int MaxIntervals = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  func_i,
  input  wire logic signed [63:0] range_lo_i,
  input  wire logic signed [63:0] range_hi_i,
  input  wire logic signed [63:0] point_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic             present_o,
  output logic             saturated_o,
  output logic [$clog2(MaxIntervals+1)-1:0] interval_count_o,
  output logic signed [63:0] hit_lo_o,
  output logic signed [63:0] hit_hi_o
);

  iis_pkg::cmd_t cmd;
  iis_pkg::sts_t sts;

  iis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  iis_dp #(.MaxIntervals(MaxIntervals)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .range_lo_i      (range_lo_i),
    .range_hi_i      (range_hi_i),
    .point_value_i   (point_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .present_o       (present_o),
    .saturated_o     (saturated_o),
    .interval_count_o(interval_count_o),
    .hit_lo_o        (hit_lo_o),
    .hit_hi_o        (hit_hi_o)
  );

endmodule
`default_nettype wire

[test/tb_integer_interval_set.sv]
`default_nettype none
module tb_integer_interval_set;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxIntervals = 16;
  localparam int DrainCycles = 4 * MaxIntervals + 40;
  localparam longint CycleLimit = 600000;

  typedef struct {
    logic [1:0] status;
    logic present;
    logic saturated;
    logic [4:0] count;
    iis_pkg::word_t hit_lo;
    iis_pkg::word_t hit_hi;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] func_i = '0;
  iis_pkg::word_t range_lo_i = '0;
  iis_pkg::word_t range_hi_i = '0;
  iis_pkg::word_t point_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic present_o;
  logic saturated_o;
  logic [4:0] interval_count_o;
  iis_pkg::word_t hit_lo_o;
  iis_pkg::word_t hit_hi_o;

  integer_interval_set #(.MaxIntervals(MaxIntervals)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .range_lo_i, .range_hi_i,
    .point_value_i, .out_valid_o, .out_ready_i, .status_o, .present_o, .saturated_o,
    .interval_count_o, .hit_lo_o, .hit_hi_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the interval table.
  iis_pkg::word_t shadow_lo [MaxIntervals + 1];
  iis_pkg::word_t shadow_hi [MaxIntervals + 1];
  int shadow_n = 0;
  outcome_t pending_outcomes [$];
  int errors = 0;
  longint cycles = 0;

  function automatic iis_pkg::word_t clamp_add(iis_pkg::word_t a, iis_pkg::word_t b,
                                               ref logic clamped);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      clamped = 1'b1;
      return s[64] ? iis_pkg::WORD_MIN : iis_pkg::WORD_MAX;
    end
    return s[63:0];
  endfunction

  function automatic iis_pkg::word_t clamp_neg(iis_pkg::word_t a, ref logic clamped);
    if (a == iis_pkg::WORD_MIN) begin
      clamped = 1'b1;
      return iis_pkg::WORD_MAX;
    end
    return -a;
  endfunction

  // Coalesces a list sorted by lower bound; returns the merged count.
  function automatic int coalesce(input iis_pkg::word_t lo [MaxIntervals + 1],
                                  input iis_pkg::word_t hi [MaxIntervals + 1],
                                  input int n,
                                  output iis_pkg::word_t olo [MaxIntervals + 1],
                                  output iis_pkg::word_t ohi [MaxIntervals + 1]);
    int m;
    m = 0;
    for (int i = 0; i < n; i++) begin
      if (m > 0 && (ohi[m-1] == iis_pkg::WORD_MAX || ohi[m-1] + 1 >= lo[i])) begin
        if (hi[i] > ohi[m-1]) ohi[m-1] = hi[i];
      end else begin
        olo[m] = lo[i];
        ohi[m] = hi[i];
        m++;
      end
    end
    return m;
  endfunction

  function automatic int locate(iis_pkg::word_t v);
    for (int i = 0; i < shadow_n; i++) begin
      if (shadow_lo[i] > v) return -1;
      if (v <= shadow_hi[i]) return i;
    end
    return -1;
  endfunction

  function automatic void shift_table(iis_pkg::word_t a, iis_pkg::word_t b,
                                      ref logic clamped);
    iis_pkg::word_t mlo [MaxIntervals + 1];
    iis_pkg::word_t mhi [MaxIntervals + 1];
    for (int i = 0; i < shadow_n; i++) begin
      shadow_lo[i] = clamp_add(shadow_lo[i], a, clamped);
      shadow_hi[i] = clamp_add(shadow_hi[i], b, clamped);
    end
    shadow_n = coalesce(shadow_lo, shadow_hi, shadow_n, mlo, mhi);
    shadow_lo = mlo;
    shadow_hi = mhi;
  endfunction

  function automatic outcome_t apply_request(logic [2:0] f, iis_pkg::word_t lo,
                                             iis_pkg::word_t hi, iis_pkg::word_t v);
    outcome_t r;
    iis_pkg::word_t tlo [MaxIntervals + 1];
    iis_pkg::word_t thi [MaxIntervals + 1];
    iis_pkg::word_t mlo [MaxIntervals + 1];
    iis_pkg::word_t mhi [MaxIntervals + 1];
    int n, i, k, m;
    logic clamped;
    iis_pkg::word_t a, b;
    r = '{default: '0};
    clamped = 1'b0;
    case (f)
      iis_pkg::FUNC_INSERT: begin
        if (lo > hi) begin
          r.status = iis_pkg::STATUS_BAD;
        end else begin
          n = 0;
          i = 0;
          while (i < shadow_n && shadow_lo[i] < lo) begin
            tlo[n] = shadow_lo[i]; thi[n] = shadow_hi[i]; n++; i++;
          end
          tlo[n] = lo; thi[n] = hi; n++;
          while (i < shadow_n) begin
            tlo[n] = shadow_lo[i]; thi[n] = shadow_hi[i]; n++; i++;
          end
          m = coalesce(tlo, thi, n, mlo, mhi);
          if (m > MaxIntervals) begin
            r.status = iis_pkg::STATUS_FULL;
          end else begin
            shadow_lo = mlo;
            shadow_hi = mhi;
            shadow_n = m;
          end
        end
      end
      iis_pkg::FUNC_DELETE: begin
        k = locate(v);
        if (k >= 0) begin
          r.present = 1'b1;
          if (shadow_lo[k] == v && shadow_hi[k] == v) begin
            for (int j = k; j + 1 < shadow_n; j++) begin
              shadow_lo[j] = shadow_lo[j+1];
              shadow_hi[j] = shadow_hi[j+1];
            end
            shadow_n--;
          end else if (shadow_lo[k] == v) begin
            shadow_lo[k] = v + 1;
          end else if (shadow_hi[k] == v) begin
            shadow_hi[k] = v - 1;
          end else if (shadow_n >= MaxIntervals) begin
            r.status = iis_pkg::STATUS_FULL;
          end else begin
            for (int j = shadow_n; j > k + 1; j--) begin
              shadow_lo[j] = shadow_lo[j-1];
              shadow_hi[j] = shadow_hi[j-1];
            end
            shadow_lo[k+1] = v + 1;
            shadow_hi[k+1] = shadow_hi[k];
            shadow_hi[k] = v - 1;
            shadow_n++;
          end
        end
      end
      iis_pkg::FUNC_QUERY: begin
        k = locate(v);
        if (k >= 0) begin
          r.present = 1'b1;
          r.hit_lo = shadow_lo[k];
          r.hit_hi = shadow_hi[k];
        end
      end
      iis_pkg::FUNC_ADD, iis_pkg::FUNC_SUB: begin
        if (lo > hi) begin
          r.status = iis_pkg::STATUS_BAD;
        end else if (f == iis_pkg::FUNC_ADD) begin
          shift_table(lo, hi, clamped);
        end else begin
          a = clamp_neg(hi, clamped);
          b = clamp_neg(lo, clamped);
          shift_table(a, b, clamped);
        end
      end
      default: ;
    endcase
    r.saturated = clamped;
    r.count = shadow_n[4:0];
    return r;
  endfunction

  task automatic send_request(logic [2:0] f, iis_pkg::word_t lo, iis_pkg::word_t hi,
                              iis_pkg::word_t v);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    range_lo_i <= lo;
    range_hi_i <= hi;
    point_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(apply_request(f, lo, hi, v));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls are drawn per result.
  int stall_left = 0;
  always @(posedge clk_i) begin
    outcome_t e;
    int gap;
    if (out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result", $realtime);
        errors++;
      end else begin
        e = pending_outcomes.pop_front();
        if (status_o !== e.status || present_o !== e.present ||
            saturated_o !== e.saturated || interval_count_o !== e.count ||
            hit_lo_o !== e.hit_lo || hit_hi_o !== e.hit_hi) begin
          $display("%0t: expected st=%0d pr=%0d sat=%0d n=%0d hit=[%0d,%0d]", $realtime,
                   e.status, e.present, e.saturated, e.count, e.hit_lo, e.hit_hi);
          $display("%0t: actual   st=%0d pr=%0d sat=%0d n=%0d hit=[%0d,%0d]", $realtime,
                   status_o, present_o, saturated_o, interval_count_o, hit_lo_o, hit_hi_o);
          errors++;
        end
      end
      gap = $urandom_range(0, 7);
      stall_left <= (gap == 0) ? 0 : gap - 1;
      out_ready_i <= (gap == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic iis_pkg::word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Values drawn near a small window so intervals collide and merge often.
  function automatic iis_pkg::word_t near_value(iis_pkg::word_t base);
    return base + $signed(64'($urandom_range(0, 200))) - 100;
  endfunction

  task automatic test_extremes();
    send_request(iis_pkg::FUNC_QUERY, 0, 0, 0);
    send_request(iis_pkg::FUNC_DELETE, 0, 0, 5);
    send_request(iis_pkg::FUNC_INSERT, 5, 3, 0);
    send_request(iis_pkg::FUNC_ADD, 1, 0, 0);
    send_request(iis_pkg::FUNC_SUB, 1, 0, 0);
    send_request(iis_pkg::FUNC_INSERT, iis_pkg::WORD_MIN, iis_pkg::WORD_MIN, 0);
    send_request(iis_pkg::FUNC_INSERT, iis_pkg::WORD_MAX, iis_pkg::WORD_MAX, 0);
    send_request(iis_pkg::FUNC_INSERT, 10, 20, 0);
    send_request(iis_pkg::FUNC_INSERT, 21, 30, 0);
    send_request(iis_pkg::FUNC_QUERY, 0, 0, 25);
    send_request(iis_pkg::FUNC_QUERY, 0, 0, iis_pkg::WORD_MAX);
    send_request(iis_pkg::FUNC_DELETE, 0, 0, 15);
    send_request(iis_pkg::FUNC_DELETE, 0, 0, 10);
    send_request(iis_pkg::FUNC_DELETE, 0, 0, 30);
    send_request(iis_pkg::FUNC_DELETE, 0, 0, iis_pkg::WORD_MIN);
    send_request(iis_pkg::FUNC_ADD, iis_pkg::WORD_MAX, iis_pkg::WORD_MAX, 0);
    send_request(iis_pkg::FUNC_SUB, iis_pkg::WORD_MIN, iis_pkg::WORD_MIN, 0);
    send_request(iis_pkg::FUNC_SUB, iis_pkg::WORD_MIN, 0, 0);
    send_request(3'd5, 1, 2, 3);
    send_request(3'd7, rand_word(), rand_word(), rand_word());
    send_request(iis_pkg::FUNC_INSERT, iis_pkg::WORD_MIN, iis_pkg::WORD_MAX, 0);
    send_request(iis_pkg::FUNC_QUERY, 0, 0, -1);
  endtask

  // Fill to the limit, then force full-table drops on split and send inserts that fit.
  task automatic test_full_table();
    send_request(iis_pkg::FUNC_DELETE, 0, 0, 0);
    send_request(iis_pkg::FUNC_INSERT, iis_pkg::WORD_MIN, iis_pkg::WORD_MAX, 0);
    for (int i = 1; i < MaxIntervals; i++) begin
      send_request(iis_pkg::FUNC_DELETE, 0, 0, 64'(i * 10));
    end
    send_request(iis_pkg::FUNC_INSERT, 500, 600, 0);
    send_request(iis_pkg::FUNC_DELETE, 0, 0, 1000);
    send_request(iis_pkg::FUNC_DELETE, 0, 0, 5);
    send_request(iis_pkg::FUNC_INSERT, 0, 0, 0);
    send_request(iis_pkg::FUNC_INSERT, iis_pkg::WORD_MIN, iis_pkg::WORD_MAX, 0);
  endtask

  task automatic test_random(int count, iis_pkg::word_t base);
    logic [2:0] f;
    iis_pkg::word_t a, b;
    for (int i = 0; i < count; i++) begin
      f = 3'($urandom_range(0, 7));
      if (f > iis_pkg::FUNC_SUB && $urandom_range(0, 3) != 0) f = iis_pkg::FUNC_INSERT;
      if ($urandom_range(0, 9) == 0) begin
        a = rand_word(); b = rand_word();
      end else begin
        a = near_value(base); b = a + 64'($urandom_range(0, 6));
      end
      if (f >= iis_pkg::FUNC_ADD && $urandom_range(0, 3) != 0) begin
        a = $signed(64'($urandom_range(0, 6))) - 3;
        b = a + $signed(64'($urandom_range(0, 4))) - 1;
      end
      if ($urandom_range(0, 15) == 0) begin
        a = b + 1;
      end
      send_request(f, a, b,
                   $urandom_range(0, 9) == 0 ? rand_word() : near_value(base));
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_full_table();
    test_random(300, 0);
    test_random(300, iis_pkg::WORD_MAX - 120);
    test_random(300, iis_pkg::WORD_MIN + 120);
    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
